### src/front_to_back_alpha_compositor_assert.svh
// Assertion macros shared by the compositor checker.
// Depends on clk and rst_n being visible in the scope that uses them.
`ifndef FRONT_TO_BACK_ALPHA_COMPOSITOR_ASSERT_SVH
`define FRONT_TO_BACK_ALPHA_COMPOSITOR_ASSERT_SVH

// Same-cycle implication
`define FTBC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ftbc: same-cycle check failed");

// Next-cycle implication
`define FTBC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ftbc: next-cycle check failed");

`endif

### src/ftbc_pkg.sv
// Shared constants, command/status types and fixed-point helpers for the compositor.
// No dependencies.
`default_nettype none

package ftbc_pkg;

    localparam int FRAC_BITS = 16;
    localparam int VW        = FRAC_BITS + 1;          // value field width
    localparam int IN_FW     = 5 * VW;                 // packed input fields
    localparam int IN_W      = ((IN_FW + 7) / 8) * 8;  // input tdata width
    localparam int OUT_FW    = 4 * VW;
    localparam int OUT_W     = ((OUT_FW + 7) / 8) * 8; // output tdata width
    localparam int USER_W    = 2;
    localparam int USER_HIT  = 0;
    localparam int USER_PREM = 1;

    localparam logic [VW-1:0] ONE_FX = {1'b1, {FRAC_BITS{1'b0}}};

    // Controller to datapath commands
    typedef struct packed {
        logic load;    // capture an input item
        logic scale;   // alpha times alpha scale
        logic colour;  // colour times rgb scale
        logic accum;   // blend into accumulators
        logic emit;    // flush to output register
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic last;      // held item closes the point
        logic out_free;  // output register can take a result
    } stat_t;

    function automatic logic [VW-1:0] clamp_one(input logic [VW-1:0] v);
        return (v > ONE_FX) ? ONE_FX : v;
    endfunction

    // Operands at most one, so the truncated product fits VW bits
    function automatic logic [VW-1:0] fx_mul(input logic [VW-1:0] a, input logic [VW-1:0] b);
        logic [2*VW-1:0] p;
        p = a * b;
        return p[FRAC_BITS +: VW];
    endfunction

    function automatic logic [VW-1:0] sat_add(input logic [VW-1:0] a, input logic [VW-1:0] b);
        logic [VW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > {1'b0, ONE_FX}) ? ONE_FX : s[VW-1:0];
    endfunction

endpackage

`default_nettype wire

### src/front_to_back_alpha_compositor.sv
// Front-to-back alpha compositor over white: one layer item in, one RGBA item per point.
// Top level; depends on ftbc_pkg, ftbc_ctrl and ftbc_datapath.
//
// Usage:
//   s_axis carries layer samples of one screen point, front layer first.
//   tdata holds red, green, blue, alpha, alpha_scale (17 bits each, 1.0 = 65536),
//   tuser holds hit and premultiplied, tlast marks the final layer of the point.
//   m_axis returns one item per point after its last layer: red, green, blue
//   over a white background and coverage alpha, all saturated at 1.0.
// Sequence:
//   Each layer steps through capture, alpha scale, colour scale and blend; the
//   running transparency product of the blend step feeds the next layer, and
//   the state machine holds one layer at a time. A last layer then goes to a
//   flush step that loads the output register once that register is free.
// Reset:
//   Accumulators clear to zero and the transparency to one; no output pending.
// Stall:
//   A waiting result sits in the output register while following layers are
//   processed; only the next flush waits for the receiver to take it.
`default_nettype none

module front_to_back_alpha_compositor
    import ftbc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [IN_W-1:0]   s_axis_tdata,  // red, green, blue, alpha, alpha_scale, pad
    input  wire logic [USER_W-1:0] s_axis_tuser,  // hit, premultiplied
    input  wire logic              s_axis_tlast,
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic [OUT_W-1:0]       m_axis_tdata   // out_red, out_green, out_blue, out_alpha, pad
);

    cmd_t  cmd;
    stat_t stat;

    ftbc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ftbc_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_data   (s_axis_tdata),
        .in_user   (s_axis_tuser),
        .in_last   (s_axis_tlast),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule

`default_nettype wire

### src/ftbc_datapath.sv
// Datapath: input capture, scaling multipliers, accumulators and output register.
// Depends on ftbc_pkg; driven by ftbc_ctrl commands.
`default_nettype none

module ftbc_datapath
    import ftbc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cmd_t              cmd,
    output stat_t                  stat,
    input  wire logic [IN_W-1:0]   in_data,
    input  wire logic [USER_W-1:0] in_user,
    input  wire logic              in_last,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [OUT_W-1:0]       out_data
);

    logic          hit_reg, prem_reg, last_reg;
    logic [VW-1:0] chan_reg [3];
    logic [VW-1:0] a_reg, sc_reg, as_reg;
    logic [VW-1:0] col_reg [3];
    logic [VW-1:0] acc_reg [3];
    logic [VW-1:0] rem_reg;
    logic [VW-1:0] out_reg [4];
    logic          out_valid_reg;

    logic [VW-1:0] col_scale;
    logic          blend;

    assign col_scale = prem_reg ? sc_reg : as_reg;
    assign blend     = hit_reg && (rem_reg != '0) && (as_reg != '0);

    assign stat.last     = last_reg;
    assign stat.out_free = !out_valid_reg || out_ready;

    // Item capture with clamping
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            hit_reg     <= in_user[USER_HIT];
            prem_reg    <= in_user[USER_PREM];
            last_reg    <= in_last;
            for (int i = 0; i < 3; i++)
            begin
                chan_reg[i] <= clamp_one(in_data[i*VW +: VW]);
            end
            a_reg       <= clamp_one(in_data[3*VW +: VW]);
            sc_reg      <= clamp_one(in_data[4*VW +: VW]);
        end
    end

    // Scaled alpha and scaled colour
    always_ff @(posedge clk)
    begin
        if (cmd.scale)
        begin
            as_reg <= fx_mul(a_reg, sc_reg);
        end
        if (cmd.colour)
        begin
            for (int i = 0; i < 3; i++)
            begin
                col_reg[i] <= fx_mul(chan_reg[i], col_scale);
            end
        end
    end

    // Accumulators and remaining transparency
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                acc_reg[i] <= '0;
            end
            rem_reg <= ONE_FX;
        end
        else if (cmd.emit)
        begin
            for (int i = 0; i < 3; i++)
            begin
                acc_reg[i] <= '0;
            end
            rem_reg <= ONE_FX;
        end
        else if (cmd.accum && blend)
        begin
            for (int i = 0; i < 3; i++)
            begin
                acc_reg[i] <= sat_add(acc_reg[i], fx_mul(col_reg[i], rem_reg));
            end
            rem_reg <= fx_mul(rem_reg, ONE_FX - as_reg);
        end
    end

    // Output register: colour over white, coverage
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            for (int i = 0; i < 3; i++)
            begin
                out_reg[i] <= sat_add(acc_reg[i], rem_reg);
            end
            out_reg[3] <= ONE_FX - rem_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = {{(OUT_W - OUT_FW){1'b0}}, out_reg[3], out_reg[2], out_reg[1],
                        out_reg[0]};

endmodule

`default_nettype wire

### src/ftbc_ctrl.sv
// Controller: steps one layer item through capture, scale, colour and blend, and flushes after a last layer.
// Depends on ftbc_pkg; drives ftbc_datapath.
`default_nettype none

module ftbc_ctrl
    import ftbc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire stat_t stat,
    output cmd_t       cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCALE  = 3'd1;
    localparam logic [2:0] ST_COLOUR = 3'd2;
    localparam logic [2:0] ST_ACCUM  = 3'd3;
    localparam logic [2:0] ST_EMIT   = 3'd4;

    logic [2:0] state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = ST_COLOUR;
            end
            ST_COLOUR:
            begin
                cmd.colour = 1'b1;
                state_next = ST_ACCUM;
            end
            ST_ACCUM:
            begin
                cmd.accum  = 1'b1;
                state_next = stat.last ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### src/ftbc_checker.sv
// Port-level checker for the compositor, bound to the top level.
// Depends on ftbc_pkg and front_to_back_alpha_compositor_assert.svh.
`default_nettype none

`include "front_to_back_alpha_compositor_assert.svh"

module ftbc_checker
    import ftbc_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              s_axis_tvalid,
    input wire logic              s_axis_tready,
    input wire logic [IN_W-1:0]   s_axis_tdata,
    input wire logic [USER_W-1:0] s_axis_tuser,
    input wire logic              s_axis_tlast,
    input wire logic              m_axis_tvalid,
    input wire logic              m_axis_tready,
    input wire logic [OUT_W-1:0]  m_axis_tdata
);

    logic [VW:0] chk_red_sum;
    logic        chk_in_acc;
    logic        chk_pad_ok;
    logic        chk_out_wait;

    // Red plus coverage is at least one: red includes the white share
    assign chk_red_sum  = {1'b0, m_axis_tdata[0 +: VW]} + {1'b0, m_axis_tdata[3*VW +: VW]};
    assign chk_in_acc   = s_axis_tvalid && s_axis_tready;
    assign chk_pad_ok   = (m_axis_tdata[OUT_W-1:OUT_FW] == '0);
    assign chk_out_wait = m_axis_tvalid && !m_axis_tready;

    `FTBC_ASSERT_NEXT(a_out_hold, chk_out_wait, m_axis_tvalid && $stable(m_axis_tdata))
    `FTBC_ASSERT_NEXT(a_one_layer, chk_in_acc, !s_axis_tready)
    `FTBC_ASSERT_NOW(a_alpha_max, m_axis_tvalid, m_axis_tdata[3*VW +: VW] <= ONE_FX)
    `FTBC_ASSERT_NOW(a_white_share, m_axis_tvalid, chk_red_sum >= {1'b0, ONE_FX})
    `FTBC_ASSERT_NOW(a_pad_zero, m_axis_tvalid, chk_pad_ok)

endmodule

bind front_to_back_alpha_compositor ftbc_checker u_ftbc_checker (.*);

`default_nettype wire
